// ===== rtl/assert_macros.svh =====
// -----------------------------------------------------------------------------
// assertion macros
// clocked, reset-qualified concurrent assertion shorthands
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define FWTBH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define FWTBH_ASSERT_IMPL(label, ante, cons, msg) \
  `FWTBH_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== rtl/fwtbh_pkg.sv =====
// -----------------------------------------------------------------------------
// fwtbh_pkg
// shared widths and constants of the take-back-half speed loop
// -----------------------------------------------------------------------------
package fwtbh_pkg;

  // transfer payload widths
  localparam int ENC_W   = 32;
  localparam int TIME_W  = 32;
  localparam int TGT_W   = 15;
  localparam int DRIVE_W = 7;
  localparam int SPD_W   = 24;

  // configuration
  localparam int KI_W       = 16;
  localparam int TPR_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_KI  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TPR = 1'b1;

  localparam logic [KI_W-1:0]  KI_RESET  = 16'd1638;
  localparam logic [TPR_W-1:0] TPR_RESET = 13'd360;

  // datapath
  localparam int SUM_W  = 40;
  localparam int QUO_W  = 24;
  localparam int RPM_W  = 16;
  localparam int NUMI_W = ENC_W + RPM_W;
  localparam int DEN_W  = TIME_W + TPR_W;

  localparam logic [RPM_W-1:0] RPM_SCALE = 16'd60000;

  localparam logic signed [SPD_W-1:0] SPD_MAX = 24'sh7FFFFF;
  localparam logic signed [SPD_W-1:0] SPD_MIN = 24'sh800000;
  localparam logic signed [SUM_W-1:0] SUM_MAX = 40'sh7FFFFFFFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 40'sh8000000000;

endpackage

// ===== rtl/fwtbh_if.sv =====
// -----------------------------------------------------------------------------
// fwtbh channel interfaces
// valid/ready channels for control ticks and loop results
// -----------------------------------------------------------------------------
interface fwtbh_in_if
  import fwtbh_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [ENC_W-1:0]  encoder_count;
  logic [TIME_W-1:0]        time_us;
  logic [TGT_W-1:0]         target_speed;

  modport source (output valid, encoder_count, time_us, target_speed, input ready);
  modport sink   (input valid, encoder_count, time_us, target_speed, output ready);
endinterface

interface fwtbh_out_if
  import fwtbh_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [DRIVE_W-1:0]       motor_drive;
  logic signed [SPD_W-1:0]  measured_speed;
  logic signed [SPD_W-1:0]  speed_error;
  logic                     zero_crossed;

  modport source (output valid, motor_drive, measured_speed, speed_error, zero_crossed,
                  input ready);
  modport sink   (input valid, motor_drive, measured_speed, speed_error, zero_crossed,
                  output ready);
endinterface

// ===== rtl/flywheel_take_back_half_speed_loop_unit.sv =====
// -----------------------------------------------------------------------------
// flywheel_take_back_half_speed_loop_unit
// take-back-half flywheel velocity controller, one result per control tick
// -----------------------------------------------------------------------------
// Each input transfer is one control tick (encoder count, microsecond time,
// target speed) and gives exactly one result transfer (motor drive, measured
// speed, speed error, zero-crossing flag). Speed is
// 60000*count_delta/(time_delta*counts_per_rev) with FRAC_BITS fraction bits,
// truncated toward zero and saturated to 24 bits; a zero time delta gives
// zero speed. One shared signed multiplier forms the numerator, the
// denominator and the integrator-times-ki product, and a restoring divider
// retires one quotient bit per cycle. From its input transfer a tick runs
// the three multiplier passes, 24 divider steps and the loop update before
// the next input transfer is possible. When the denominator is zero or the
// quotient saturates the divider is skipped. A finished result sits in an
// output register, so the next tick is taken while it waits; the loop only
// stalls at its last step if the previous result is still not taken. ki and
// counts_per_rev are written through cfg_we/cfg_index/cfg_wdata; the user
// must write them only while the block is idle; the block does not enforce it.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module flywheel_take_back_half_speed_loop_unit
  import fwtbh_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fwtbh_in_if.sink              in_ch,
  fwtbh_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // derived widths
  localparam int NUM_W   = NUMI_W + FRAC_BITS;           // scaled numerator
  localparam int DIV_W   = DEN_W + QUO_W;                // denominator << quotient bits
  localparam int RW      = (NUM_W > DIV_W) ? NUM_W : DIV_W;
  localparam int MUL_AW  = SUM_W + 1;
  localparam int MUL_BW  = KI_W + 1;
  localparam int PROD_W  = MUL_AW + MUL_BW;
  localparam int SH_W    = PROD_W - KI_W;                // product after ki scaling
  localparam int DRV_W   = DRIVE_W + FRAC_BITS;
  localparam int TW      = TGT_W + FRAC_BITS;
  localparam int EW      = ((TW > SPD_W) ? TW : SPD_W) + 2;
  localparam int QCNT_W  = $clog2(QUO_W);

  localparam logic [DRV_W-1:0] DRV_MAX = {{DRIVE_W{1'b1}}, {FRAC_BITS{1'b0}}};

  // error sign codes
  localparam logic [1:0] SIGN_ZERO = 2'b00;
  localparam logic [1:0] SIGN_POS  = 2'b01;
  localparam logic [1:0] SIGN_NEG  = 2'b11;

  // sequencer states
  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE    = 4'd0;
  localparam logic [ST_W-1:0] S_MUL_NUM = 4'd1;  // |count delta| * 60000
  localparam logic [ST_W-1:0] S_MUL_DEN = 4'd2;  // time delta * counts per revolution
  localparam logic [ST_W-1:0] S_CHK     = 4'd3;  // zero divisor / overflow, divider setup
  localparam logic [ST_W-1:0] S_DIV     = 4'd4;  // one quotient bit a cycle
  localparam logic [ST_W-1:0] S_SPD     = 4'd5;  // speed, error, error sign
  localparam logic [ST_W-1:0] S_SUM     = 4'd6;  // saturating integrator
  localparam logic [ST_W-1:0] S_MUL_DRV = 4'd7;  // integrator * ki
  localparam logic [ST_W-1:0] S_DRV     = 4'd8;  // drive scaling and clamp
  localparam logic [ST_W-1:0] S_FIN     = 4'd9;  // take-back-half and result load

  // control and persistent state
  logic [ST_W-1:0]          state_r, state_nxt;
  logic [QCNT_W-1:0]        cnt_r;
  logic [KI_W-1:0]          ki_r;
  logic [TPR_W-1:0]         tpr_r;
  logic [ENC_W-1:0]         last_enc_r;
  logic [TIME_W-1:0]        last_time_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [DRV_W-1:0]         tbh_r;
  logic [1:0]               stored_sign_r;
  logic                     out_valid_r;

  // per-tick working registers
  logic                     neg_r;
  logic [ENC_W-1:0]         mag_r;
  logic [TIME_W-1:0]        dt_r;
  logic [TGT_W-1:0]         tgt_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [NUM_W-1:0]         num_r;
  logic [RW-1:0]            rem_r;
  logic [RW-1:0]            d_r;
  logic [QUO_W-1:0]         q_r;
  logic signed [SPD_W-1:0]  speed_r;
  logic signed [SPD_W-1:0]  err_r;
  logic [1:0]               sign_r;
  logic [DRV_W-1:0]         drive_r;

  // result register
  logic [DRIVE_W-1:0]       o_drive_r;
  logic signed [SPD_W-1:0]  o_speed_r;
  logic signed [SPD_W-1:0]  o_err_r;
  logic                     o_crossed_r;

  // handshake terms
  logic in_xfer;
  logic out_xfer;
  logic fin_go;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_valid_r && out_ch.ready;
  // last step waits only while an untaken result holds the output register
  assign fin_go      = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid          = out_valid_r;
  assign out_ch.motor_drive    = o_drive_r;
  assign out_ch.measured_speed = o_speed_r;
  assign out_ch.speed_error    = o_err_r;
  assign out_ch.zero_crossed   = o_crossed_r;

  // ---------------------------------------------------------------------------
  // input deltas: count delta is signed mod 2^32, time delta unsigned mod 2^32
  // ---------------------------------------------------------------------------
  logic [ENC_W-1:0]  dc_raw;
  logic [ENC_W-1:0]  dc_mag;
  logic [TIME_W-1:0] dt_raw;

  assign dc_raw = in_ch.encoder_count - last_enc_r;
  assign dt_raw = in_ch.time_us - last_time_r;
  // the most negative delta negates to itself, which is the right magnitude
  assign dc_mag = dc_raw[ENC_W-1] ? (~dc_raw + 1'b1) : dc_raw;

  // ---------------------------------------------------------------------------
  // shared multiplier: operands chosen by the sequencer
  // ---------------------------------------------------------------------------
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;

  always_comb begin
    if (state_r == S_MUL_NUM) begin
      mul_a = signed'(MUL_AW'(mag_r));
      mul_b = signed'(MUL_BW'(RPM_SCALE));
    end else if (state_r == S_MUL_DEN) begin
      mul_a = signed'(MUL_AW'(dt_r));
      mul_b = signed'(MUL_BW'(tpr_r));
    end else begin
      mul_a = MUL_AW'(sum_r);
      mul_b = signed'(MUL_BW'(ki_r));
    end
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // ---------------------------------------------------------------------------
  // divider setup and step
  // ---------------------------------------------------------------------------
  logic [DEN_W-1:0] den;
  logic             den_zero;
  logic             quo_ovf;
  logic             rem_ge;
  logic [RW-1:0]    rem_sub;

  assign den      = prod_r[DEN_W-1:0];
  assign den_zero = (den == '0);
  // quotient would need more than QUO_W bits: saturates anyway
  assign quo_ovf  = RW'(num_r) >= RW'({den, {QUO_W{1'b0}}});
  assign rem_ge   = rem_r >= d_r;
  assign rem_sub  = rem_r - d_r;

  // ---------------------------------------------------------------------------
  // speed and error
  // ---------------------------------------------------------------------------
  logic signed [SPD_W-1:0] speed_nxt;
  logic signed [EW-1:0]    err_wide;
  logic signed [SPD_W-1:0] err_nxt;
  logic [1:0]              sign_nxt;

  always_comb begin
    // q_r[msb] set means the magnitude reached the saturation point
    if (neg_r) begin
      speed_nxt = q_r[QUO_W-1] ? SPD_MIN : SPD_W'(-$signed({1'b0, q_r}));
    end else begin
      speed_nxt = q_r[QUO_W-1] ? SPD_MAX : signed'(q_r);
    end
    err_wide = signed'(EW'({tgt_r, {FRAC_BITS{1'b0}}})) - EW'(speed_nxt);
    if (err_wide > EW'(SPD_MAX)) begin
      err_nxt = SPD_MAX;
    end else if (err_wide < EW'(SPD_MIN)) begin
      err_nxt = SPD_MIN;
    end else begin
      err_nxt = err_wide[SPD_W-1:0];
    end
    if (err_nxt == '0) begin
      sign_nxt = SIGN_ZERO;
    end else if (err_nxt[SPD_W-1]) begin
      sign_nxt = SIGN_NEG;
    end else begin
      sign_nxt = SIGN_POS;
    end
  end

  // ---------------------------------------------------------------------------
  // integrator, drive, take-back-half
  // ---------------------------------------------------------------------------
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_nxt;
  logic [SH_W-1:0]         prod_sh;
  logic [DRV_W-1:0]        drive_nxt;
  logic [DRV_W:0]          tbh_sum;
  logic [DRV_W-1:0]        tbh_avg;
  logic                    crossed;

  always_comb begin
    sum_wide = (SUM_W+1)'(sum_r) + (SUM_W+1)'(err_r);
    if (sum_wide > (SUM_W+1)'(SUM_MAX)) begin
      sum_nxt = SUM_MAX;
    end else if (sum_wide < (SUM_W+1)'(SUM_MIN)) begin
      sum_nxt = SUM_MIN;
    end else begin
      sum_nxt = sum_wide[SUM_W-1:0];
    end
  end

  assign prod_sh = prod_r[PROD_W-1:KI_W];

  always_comb begin
    if (prod_r[PROD_W-1]) begin
      drive_nxt = '0;
    end else if (prod_sh > SH_W'(DRV_MAX)) begin
      drive_nxt = DRV_MAX;
    end else begin
      drive_nxt = prod_sh[DRV_W-1:0];
    end
  end

  assign crossed = (sign_r != stored_sign_r);
  assign tbh_sum = (DRV_W+1)'(drive_r) + (DRV_W+1)'(tbh_r);
  assign tbh_avg = tbh_sum[DRV_W:1];

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_xfer) state_nxt = S_MUL_NUM;
      S_MUL_NUM: state_nxt = S_MUL_DEN;
      S_MUL_DEN: state_nxt = S_CHK;
      S_CHK:     state_nxt = (den_zero || quo_ovf) ? S_SPD : S_DIV;
      S_DIV:     if (cnt_r == '0) state_nxt = S_SPD;
      S_SPD:     state_nxt = S_SUM;
      S_SUM:     state_nxt = S_MUL_DRV;
      S_MUL_DRV: state_nxt = S_DRV;
      S_DRV:     state_nxt = S_FIN;
      S_FIN:     if (fin_go) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // control state, configuration and loop memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      ki_r          <= KI_RESET;
      tpr_r         <= TPR_RESET;
      last_enc_r    <= '0;
      last_time_r   <= '0;
      sum_r         <= '0;
      tbh_r         <= '0;
      stored_sign_r <= SIGN_ZERO;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KI:  ki_r  <= cfg_wdata[KI_W-1:0];
          CFG_TPR: tpr_r <= cfg_wdata[TPR_W-1:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        last_enc_r  <= in_ch.encoder_count;
        last_time_r <= in_ch.time_us;
      end
      if (state_r == S_SUM) begin
        sum_r <= sum_nxt;
      end
      if (fin_go && crossed) begin
        tbh_r         <= tbh_avg;
        stored_sign_r <= sign_r;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working datapath and result register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      neg_r <= dc_raw[ENC_W-1];
      mag_r <= dc_mag;
      dt_r  <= dt_raw;
      tgt_r <= in_ch.target_speed;
    end
    if ((state_r == S_MUL_NUM) || (state_r == S_MUL_DEN) || (state_r == S_MUL_DRV)) begin
      prod_r <= mul_p;
    end
    if (state_r == S_MUL_DEN) begin
      num_r <= {prod_r[NUMI_W-1:0], {FRAC_BITS{1'b0}}};
    end
    if (state_r == S_CHK) begin
      rem_r <= RW'(num_r);
      d_r   <= RW'({den, {(QUO_W-1){1'b0}}});
      cnt_r <= QCNT_W'(QUO_W - 1);
      if (den_zero) begin
        q_r <= '0;
      end else if (quo_ovf) begin
        q_r <= {1'b1, {(QUO_W-1){1'b0}}};
      end else begin
        q_r <= '0;
      end
    end
    if (state_r == S_DIV) begin
      if (rem_ge) begin
        rem_r <= rem_sub;
      end
      q_r   <= {q_r[QUO_W-2:0], rem_ge};
      d_r   <= d_r >> 1;
      cnt_r <= cnt_r - 1'b1;
    end
    if (state_r == S_SPD) begin
      speed_r <= speed_nxt;
      err_r   <= err_nxt;
      sign_r  <= sign_nxt;
    end
    if (state_r == S_DRV) begin
      drive_r <= drive_nxt;
    end
    if (fin_go) begin
      o_drive_r   <= crossed ? tbh_avg[DRV_W-1:FRAC_BITS] : drive_r[DRV_W-1:FRAC_BITS];
      o_speed_r   <= speed_r;
      o_err_r     <= err_r;
      o_crossed_r <= crossed;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a result only appears out of the last sequencer step
  `FWTBH_ASSERT_IMPL(a_result_from_fin, $rose(out_valid_r), $past(state_r) == S_FIN, "result without loop completion")
  // restoring division keeps the partial remainder below twice the divisor
  `FWTBH_ASSERT_IMPL(a_div_rem_bound, state_r == S_DIV, rem_r < (d_r << 1), "divider remainder out of range")
  // step counter stays inside the quotient width
  `FWTBH_ASSERT_IMPL(a_div_cnt_range, state_r == S_DIV, cnt_r <= QCNT_W'(QUO_W - 1), "divider step count out of range")
  // take-back-half value never exceeds the drive ceiling
  `FWTBH_ASSERT(a_tbh_bound, tbh_r <= DRV_MAX, "take-back-half value above drive limit")

endmodule
